// ===== design/assert_macros.svh =====
// assertion helpers, sampled on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AGP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("agp assertion failed");

// next-cycle implication
`define AGP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("agp assertion failed");

`endif

// ===== design/agp_pkg.sv =====
`timescale 1ns / 1ps
package agp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STEPS_PER_STAGE = 2;
	localparam int WORD_W = 32;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 64;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PROJ_X_A = 4'd0,
		CFG_PROJ_X_B = 4'd1,
		CFG_PROJ_Y_A = 4'd2,
		CFG_PROJ_Y_B = 4'd3,
		CFG_PROJ_W_A = 4'd4,
		CFG_PROJ_W_B = 4'd5,
		CFG_ARROW_SCALE = 4'd6,
		CFG_HEAD_SIZE = 4'd7
	} cfg_index_t;

	// shaft data that rides along the square root and unit divide
	typedef struct packed {
		logic [30:0] an;
		logic [30:0] bn;
		logic neg_x;
		logic neg_y;
		logic nz;
		word_t p0x;
		word_t p0y;
		word_t p1x;
		word_t p1y;
	} shaft_t;

	function automatic word_t sat32(input logic signed [63:0] v);
		if (v > 64'(WORD_MAX)) return WORD_MAX;
		if (v < 64'(WORD_MIN)) return WORD_MIN;
		return v[WORD_W-1:0];
	endfunction
endpackage

// ===== design/agp_ifs.sv =====
`timescale 1ns / 1ps
interface agp_arrow_if import agp_pkg::*;;
	logic valid;
	logic ready;
	word_t base_x;
	word_t base_y;
	word_t base_z;
	word_t dir_u;
	word_t dir_v;
	word_t dir_w;
	modport source(output valid, base_x, base_y, base_z, dir_u, dir_v, dir_w, input ready);
	modport sink(input valid, base_x, base_y, base_z, dir_u, dir_v, dir_w, output ready);
endinterface

interface agp_glyph_if import agp_pkg::*;;
	logic valid;
	logic ready;
	word_t start_sx;
	word_t start_sy;
	word_t tip_sx;
	word_t tip_sy;
	word_t corner_a_x;
	word_t corner_a_y;
	word_t corner_b_x;
	word_t corner_b_y;
	logic head_valid;
	modport source(output valid, start_sx, start_sy, tip_sx, tip_sy, corner_a_x, corner_a_y,
		corner_b_x, corner_b_y, head_valid, input ready);
	modport sink(input valid, start_sx, start_sy, tip_sx, tip_sy, corner_a_x, corner_a_y,
		corner_b_x, corner_b_y, head_valid, output ready);
endinterface

// ===== design/agp_div_pipe.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, quo = floor(num / den), caller guarantees quo < 2**QW
module agp_div_pipe import agp_pkg::*; #(
	parameter int LANES = 1,
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [NW-1:0] num [LANES],
	input logic [DW-1:0] den [LANES],
	input logic [SW-1:0] side,
	output logic out_valid,
	output logic [QW-1:0] quo [LANES],
	output logic [SW-1:0] side_out
);
	localparam int NS = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic valid_s [NS];
	logic [SW-1:0] side_s [NS];
	logic [DW-1:0] rem_s [NS][LANES];
	logic [QW-1:0] low_s [NS][LANES];
	logic [QW-1:0] q_s [NS][LANES];
	logic [DW-1:0] den_s [NS][LANES];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic v_i;
		logic [SW-1:0] side_i;
		logic [DW-1:0] rem_i [LANES];
		logic [QW-1:0] low_i [LANES];
		logic [QW-1:0] q_i [LANES];
		logic [DW-1:0] den_i [LANES];
		logic [DW-1:0] rem_o [LANES];
		logic [QW-1:0] low_o [LANES];
		logic [QW-1:0] q_o [LANES];

		if (k == 0) begin : g_first
			always_comb begin
				v_i = in_valid;
				side_i = side;
				for (int l = 0; l < LANES; l++) begin
					// upper numerator bits seed the remainder
					rem_i[l] = DW'(num[l] >> QW);
					low_i[l] = num[l][QW-1:0];
					q_i[l] = '0;
					den_i[l] = den[l];
				end
			end
		end else begin : g_next
			always_comb begin
				v_i = valid_s[k-1];
				side_i = side_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_i[l] = rem_s[k-1][l];
					low_i[l] = low_s[k-1][l];
					q_i[l] = q_s[k-1][l];
					den_i[l] = den_s[k-1][l];
				end
			end
		end

		always_comb begin
			logic [DW:0] t;
			logic b;
			t = '0;
			b = 1'b0;
			for (int l = 0; l < LANES; l++) begin
				rem_o[l] = rem_i[l];
				low_o[l] = low_i[l];
				q_o[l] = q_i[l];
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					if (k * STEPS_PER_STAGE + j < QW) begin
						t = {rem_o[l], low_o[l][QW-1]};
						b = (t >= {1'b0, den_i[l]});
						if (b) t = t - {1'b0, den_i[l]};
						rem_o[l] = t[DW-1:0];
						low_o[l] = low_o[l] << 1;
						q_o[l] = {q_o[l][QW-2:0], b};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_i;
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= rem_o[l];
					low_s[k][l] <= low_o[l];
					q_s[k][l] <= q_o[l];
					den_s[k][l] <= den_i[l];
				end
			end
		end
	end

	assign out_valid = valid_s[NS-1];
	assign side_out = side_s[NS-1];
	always_comb begin
		for (int l = 0; l < LANES; l++) quo[l] = q_s[NS-1][l];
	end
endmodule

// ===== design/agp_isqrt_pipe.sv =====
`timescale 1ns / 1ps
// pipelined floor square root of a 64-bit radicand, digit-pair method
module agp_isqrt_pipe import agp_pkg::*; #(
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [63:0] rad,
	input logic [SW-1:0] side,
	output logic out_valid,
	output logic [31:0] root,
	output logic [SW-1:0] side_out
);
	localparam int ITER = 32;
	localparam int NS = (ITER + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic valid_s [NS];
	logic [SW-1:0] side_s [NS];
	logic [63:0] rem_s [NS];
	logic [63:0] res_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic v_i;
		logic [SW-1:0] side_i;
		logic [63:0] rem_i, res_i, rem_o, res_o;

		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign side_i = side;
			assign rem_i = rad;
			assign res_i = '0;
		end else begin : g_next
			assign v_i = valid_s[k-1];
			assign side_i = side_s[k-1];
			assign rem_i = rem_s[k-1];
			assign res_i = res_s[k-1];
		end

		always_comb begin
			logic [63:0] bitv;
			bitv = '0;
			rem_o = rem_i;
			res_o = res_i;
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if (k * STEPS_PER_STAGE + j < ITER) begin
					bitv = 64'(1) << (62 - 2 * (k * STEPS_PER_STAGE + j));
					if (rem_o >= res_o + bitv) begin
						rem_o = rem_o - (res_o + bitv);
						res_o = (res_o >> 1) + bitv;
					end else begin
						res_o = res_o >> 1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_i;
				rem_s[k] <= rem_o;
				res_s[k] <= res_o;
			end
		end
	end

	assign out_valid = valid_s[NS-1];
	assign side_out = side_s[NS-1];
	assign root = res_s[NS-1][31:0];
endmodule

// ===== design/arrow_glyph_projector.sv =====
`timescale 1ns / 1ps
// Arrow glyph projector: takes one arrow (base point and direction, signed fixed point with
// FRAC_BITS fraction bits) per cycle and returns its projected start and tip points and the
// two arrowhead corners. Fully pipelined, one arrow accepted every cycle when the output is
// taken. The pipeline holds the 32-bit perspective divider and the square root, each
// retiring two bits per stage, and the unit-vector divider. A stalled output holds the whole
// pipeline. Configuration registers are written through cfg_we/cfg_index/cfg_wdata, and only
// while no arrow is in flight; the user must keep to this, the block does not enforce it.
module arrow_glyph_projector import agp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	agp_arrow_if.sink arrow,
	agp_glyph_if.source glyph
);
	localparam int UW = FRAC_BITS + 2;
	localparam int PROJ_NW = 64 + FRAC_BITS;
	localparam int UNIT_NW = 31 + FRAC_BITS;
	localparam int OVW = 96 - FRAC_BITS;
	localparam int SIDE_W = $bits(shaft_t);
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	// configuration
	logic [63:0] proj_q [6];
	word_t scale_q;
	logic [63:0] head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q[0] <= ONE;
			proj_q[1] <= '0;
			proj_q[2] <= ONE << 32;
			proj_q[3] <= '0;
			proj_q[4] <= '0;
			proj_q[5] <= ONE << 32;
			scale_q <= ONE[31:0];
			head_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PROJ_X_A: proj_q[0] <= cfg_wdata;
				CFG_PROJ_X_B: proj_q[1] <= cfg_wdata;
				CFG_PROJ_Y_A: proj_q[2] <= cfg_wdata;
				CFG_PROJ_Y_B: proj_q[3] <= cfg_wdata;
				CFG_PROJ_W_A: proj_q[4] <= cfg_wdata;
				CFG_PROJ_W_B: proj_q[5] <= cfg_wdata;
				CFG_ARROW_SCALE: scale_q <= cfg_wdata[31:0];
				CFG_HEAD_SIZE: head_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	word_t mat [3][4];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mat[r][0] = proj_q[2*r][31:0];
			mat[r][1] = proj_q[2*r][63:32];
			mat[r][2] = proj_q[2*r+1][31:0];
			mat[r][3] = proj_q[2*r+1][63:32];
		end
	end

	word_t hl, hw;
	assign hl = head_q[31:0];
	assign hw = head_q[63:32];

	logic en;
	logic valid_s13;
	assign en = !valid_s13 || glyph.ready;
	assign arrow.ready = en;

	// stage 1: scale times direction
	logic valid_s1;
	word_t base_s1 [3];
	logic signed [63:0] sd_s1 [3];
	word_t base_in [3], dir_in [3];
	assign base_in[0] = arrow.base_x;
	assign base_in[1] = arrow.base_y;
	assign base_in[2] = arrow.base_z;
	assign dir_in[0] = arrow.dir_u;
	assign dir_in[1] = arrow.dir_v;
	assign dir_in[2] = arrow.dir_w;

	// stage 2: tip point
	logic valid_s2;
	word_t pt_s2 [2][3];

	// stage 3: matrix products
	logic valid_s3;
	logic signed [63:0] prod_s3 [2][3][3];
	logic signed [63:0] prod_n [2][3][3];

	// stage 4: clip coordinates
	logic valid_s4;
	logic signed [63:0] clip_s4 [2][3];

	// stage 5: divider operands, lanes are base x, base y, tip x, tip y
	logic valid_s5;
	logic [63:0] nmag_s5 [4], dmag_s5 [4];
	logic [3:0] neg_s5, ovf_s5, zero_s5;
	logic [63:0] nmag_n [4], dmag_n [4];
	logic [3:0] neg_n, ovf_n, zero_n;

	always_comb begin
		logic signed [63:0] full;
		logic signed [63:0] nv, dv;
		full = '0;
		nv = '0;
		dv = '0;
		for (int p = 0; p < 2; p++)
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					full = mat[r][c] * pt_s2[p][c];
					prod_n[p][r][c] = full >>> FRAC_BITS;
				end
		for (int l = 0; l < 4; l++) begin
			nv = clip_s4[l >> 1][l & 1];
			dv = clip_s4[l >> 1][2];
			nmag_n[l] = nv[63] ? -nv : nv;
			dmag_n[l] = dv[63] ? -dv : dv;
			neg_n[l] = nv[63] ^ dv[63];
			zero_n[l] = (dv == 64'sd0);
			// integer part would not fit the result word
			ovf_n[l] = OVW'(nmag_n[l]) >= {dmag_n[l], {(32 - FRAC_BITS){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= arrow.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				base_s1[i] <= base_in[i];
				sd_s1[i] <= scale_q * dir_in[i];
				pt_s2[0][i] <= base_s1[i];
				pt_s2[1][i] <= sat32(64'(base_s1[i]) + (sd_s1[i] >>> FRAC_BITS));
			end
			prod_s3 <= prod_n;
			for (int p = 0; p < 2; p++)
				for (int r = 0; r < 3; r++)
					clip_s4[p][r] <= prod_s3[p][r][0] + prod_s3[p][r][1] + prod_s3[p][r][2]
						+ 64'(mat[r][3]);
			nmag_s5 <= nmag_n;
			dmag_s5 <= dmag_n;
			neg_s5 <= neg_n;
			ovf_s5 <= ovf_n;
			zero_s5 <= zero_n;
		end
	end

	// perspective divide
	logic [PROJ_NW-1:0] pnum [4];
	logic [31:0] pq [4];
	logic [11:0] pside;
	logic pvalid;
	always_comb begin
		for (int l = 0; l < 4; l++) pnum[l] = {nmag_s5[l], {FRAC_BITS{1'b0}}};
	end

	agp_div_pipe #(
		.LANES(4), .NW(PROJ_NW), .DW(64), .QW(32), .SW(12)
	) u_proj_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s5),
		.num(pnum), .den(dmag_s5), .side({neg_s5, ovf_s5, zero_s5}),
		.out_valid(pvalid), .quo(pq), .side_out(pside)
	);

	// stage 6: signed, saturated screen points
	logic valid_s6;
	word_t p_s6 [4];
	word_t p_n [4];
	always_comb begin
		logic signed [63:0] qv;
		qv = '0;
		for (int l = 0; l < 4; l++) begin
			qv = $signed({32'b0, pq[l]});
			if (pside[8 + l]) qv = -qv;
			if (pside[l]) p_n[l] = '0;
			else if (pside[4 + l]) p_n[l] = pside[8 + l] ? WORD_MIN : WORD_MAX;
			else p_n[l] = sat32(qv);
		end
	end

	// stage 7: shaft magnitudes and leading zeros
	logic valid_s7;
	logic [31:0] a_s7, b_s7;
	logic [5:0] lz_s7;
	logic big_s7, nz_s7, negx_s7, negy_s7;
	word_t p_s7 [4];
	logic signed [32:0] dx, dy;
	logic [31:0] amag, bmag, mor;
	logic [5:0] lz_n;
	assign dx = 33'(p_s6[2]) - 33'(p_s6[0]);
	assign dy = 33'(p_s6[3]) - 33'(p_s6[1]);
	assign amag = dx[32] ? 32'(-dx) : dx[31:0];
	assign bmag = dy[32] ? 32'(-dy) : dy[31:0];
	assign mor = amag | bmag;
	always_comb begin
		lz_n = 6'd32;
		for (int i = 0; i < 32; i++) if (mor[i]) lz_n = 6'(31 - i);
	end

	// stage 8: normalize so the larger magnitude lands in [2^30, 2^31)
	logic valid_s8;
	shaft_t sh_s8, sh_n8;
	logic [4:0] lsh;
	logic [31:0] a_sh, b_sh;
	assign lsh = 5'(lz_s7 - 6'd1);
	assign a_sh = a_s7 << lsh;
	assign b_sh = b_s7 << lsh;
	always_comb begin
		sh_n8.an = big_s7 ? a_s7[31:1] : a_sh[30:0];
		sh_n8.bn = big_s7 ? b_s7[31:1] : b_sh[30:0];
		sh_n8.neg_x = negx_s7;
		sh_n8.neg_y = negy_s7;
		sh_n8.nz = nz_s7;
		sh_n8.p0x = p_s7[0];
		sh_n8.p0y = p_s7[1];
		sh_n8.p1x = p_s7[2];
		sh_n8.p1y = p_s7[3];
	end

	// stages 9 and 10: squared length
	logic valid_s9, valid_s10;
	shaft_t sh_s9, sh_s10;
	logic [61:0] sqa_s9, sqb_s9;
	logic [62:0] sum_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s6 <= pvalid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6 <= p_n;
			a_s7 <= amag;
			b_s7 <= bmag;
			lz_s7 <= lz_n;
			big_s7 <= mor[31];
			nz_s7 <= (mor != 32'd0);
			negx_s7 <= dx[32];
			negy_s7 <= dy[32];
			p_s7 <= p_s6;
			sh_s8 <= sh_n8;
			sh_s9 <= sh_s8;
			sqa_s9 <= 62'(sh_s8.an) * 62'(sh_s8.an);
			sqb_s9 <= 62'(sh_s8.bn) * 62'(sh_s8.bn);
			sh_s10 <= sh_s9;
			sum_s10 <= 63'(sqa_s9) + 63'(sqb_s9);
		end
	end

	// shaft length
	logic rvalid;
	logic [31:0] root;
	logic [SIDE_W-1:0] rside;
	shaft_t sh_r;

	agp_isqrt_pipe #(.SW(SIDE_W)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s10),
		.rad(64'(sum_s10)), .side(sh_s10),
		.out_valid(rvalid), .root(root), .side_out(rside)
	);
	assign sh_r = shaft_t'(rside);

	// unit vector magnitudes
	logic [UNIT_NW-1:0] unum [2];
	logic [31:0] uden [2];
	logic [FRAC_BITS:0] uq [2];
	logic [SIDE_W-1:0] uside;
	logic uvalid;
	shaft_t sh_u;
	assign unum[0] = {sh_r.an, {FRAC_BITS{1'b0}}};
	assign unum[1] = {sh_r.bn, {FRAC_BITS{1'b0}}};
	assign uden[0] = root;
	assign uden[1] = root;

	agp_div_pipe #(
		.LANES(2), .NW(UNIT_NW), .DW(32), .QW(FRAC_BITS + 1), .SW(SIDE_W)
	) u_unit_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(rvalid),
		.num(unum), .den(uden), .side(rside),
		.out_valid(uvalid), .quo(uq), .side_out(uside)
	);
	assign sh_u = shaft_t'(uside);

	// stage 11: signed unit vector
	logic valid_s11;
	shaft_t sh_s11;
	logic signed [UW-1:0] ux_s11, uy_s11;

	// stage 12: head offsets, ux*hl, uy*hl, uy*hw, ux*hw
	logic valid_s12;
	shaft_t sh_s12;
	logic signed [33:0] ph_s12 [4];
	logic signed [33:0] ph_n [4];
	always_comb begin
		logic signed [63:0] full;
		full = ux_s11 * hl;
		full = full >>> FRAC_BITS;
		ph_n[0] = full[33:0];
		full = uy_s11 * hl;
		full = full >>> FRAC_BITS;
		ph_n[1] = full[33:0];
		full = uy_s11 * hw;
		full = full >>> FRAC_BITS;
		ph_n[2] = full[33:0];
		full = ux_s11 * hw;
		full = full >>> FRAC_BITS;
		ph_n[3] = full[33:0];
	end

	// stage 13: corners, output register
	word_t start_sx_s13, start_sy_s13, tip_sx_s13, tip_sy_s13;
	word_t ca_x_s13, ca_y_s13, cb_x_s13, cb_y_s13;
	logic head_s13;
	logic signed [63:0] back_x, back_y;
	assign back_x = 64'(sh_s12.p1x) - 64'(ph_s12[0]);
	assign back_y = 64'(sh_s12.p1y) - 64'(ph_s12[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
		end else if (en) begin
			valid_s11 <= uvalid;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s11 <= sh_u;
			ux_s11 <= sh_u.neg_x ? -$signed(UW'(uq[0])) : $signed(UW'(uq[0]));
			uy_s11 <= sh_u.neg_y ? -$signed(UW'(uq[1])) : $signed(UW'(uq[1]));
			sh_s12 <= sh_s11;
			ph_s12 <= ph_n;
			start_sx_s13 <= sh_s12.p0x;
			start_sy_s13 <= sh_s12.p0y;
			tip_sx_s13 <= sh_s12.p1x;
			tip_sy_s13 <= sh_s12.p1y;
			head_s13 <= sh_s12.nz;
			if (sh_s12.nz) begin
				ca_x_s13 <= sat32(back_x - 64'(ph_s12[2]));
				ca_y_s13 <= sat32(back_y + 64'(ph_s12[3]));
				cb_x_s13 <= sat32(back_x + 64'(ph_s12[2]));
				cb_y_s13 <= sat32(back_y - 64'(ph_s12[3]));
			end else begin
				ca_x_s13 <= '0;
				ca_y_s13 <= '0;
				cb_x_s13 <= '0;
				cb_y_s13 <= '0;
			end
		end
	end

	assign glyph.valid = valid_s13;
	assign glyph.start_sx = start_sx_s13;
	assign glyph.start_sy = start_sy_s13;
	assign glyph.tip_sx = tip_sx_s13;
	assign glyph.tip_sy = tip_sy_s13;
	assign glyph.corner_a_x = ca_x_s13;
	assign glyph.corner_a_y = ca_y_s13;
	assign glyph.corner_b_x = cb_x_s13;
	assign glyph.corner_b_y = cb_y_s13;
	assign glyph.head_valid = head_s13;
endmodule

// ===== design/agp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module agp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] start_sx,
	input logic signed [31:0] start_sy,
	input logic signed [31:0] tip_sx,
	input logic signed [31:0] tip_sy,
	input logic signed [31:0] corner_a_x,
	input logic signed [31:0] corner_a_y,
	input logic signed [31:0] corner_b_x,
	input logic signed [31:0] corner_b_y,
	input logic head_valid
);
	logic shaft_nz, corners_zero;
	assign shaft_nz = (start_sx != tip_sx) || (start_sy != tip_sy);
	assign corners_zero = (corner_a_x == 0) && (corner_a_y == 0)
		&& (corner_b_x == 0) && (corner_b_y == 0);

	// a result that is not taken stays offered
	`AGP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// input side moves exactly when the output register can move
	`AGP_ASSERT_IMPL(a_in_ready, 1'b1, in_ready == (!out_valid || out_ready))
	// head flag follows the projected shaft length
	`AGP_ASSERT_IMPL(a_head_shaft, out_valid, head_valid == shaft_nz)
	// degenerate shaft gives cleared corners
	`AGP_ASSERT_IMPL(a_no_head, out_valid && !head_valid, corners_zero)
endmodule

bind arrow_glyph_projector agp_checker u_agp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(arrow.ready),
	.out_valid(glyph.valid),
	.out_ready(glyph.ready),
	.start_sx(glyph.start_sx),
	.start_sy(glyph.start_sy),
	.tip_sx(glyph.tip_sx),
	.tip_sy(glyph.tip_sy),
	.corner_a_x(glyph.corner_a_x),
	.corner_a_y(glyph.corner_a_y),
	.corner_b_x(glyph.corner_b_x),
	.corner_b_y(glyph.corner_b_y),
	.head_valid(glyph.head_valid)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import agp_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 5000;
	localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED = 4'hf;
	localparam word_t ONE = 32'sh00010000;

	typedef struct {
		word_t bx, by, bz, du, dv, dw;
	} arrow_t;

	typedef struct {
		word_t ssx, ssy, tsx, tsy, ax, ay, cx, cy;
		logic hv;
	} glyph_t;

	typedef struct {
		arrow_t a;
		bit typed;
		glyph_t g;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	agp_arrow_if arrow();
	agp_glyph_if glyph();

	arrow_glyph_projector u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .arrow(arrow.sink), .glyph(glyph.source)
	);

	always #5 clk = ~clk;

	// shadow of the block's registers
	logic [63:0] m_xa, m_xb, m_ya, m_yb, m_wa, m_wb, m_head;
	logic [31:0] m_scale;

	glyph_t pending_glyphs[$];
	stim_row_t rows[$];
	int errors = 0;
	bit calm = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	initial begin
		arrow.valid = 0;
		arrow.base_x = '0;
		arrow.base_y = '0;
		arrow.base_z = '0;
		arrow.dir_u = '0;
		arrow.dir_v = '0;
		arrow.dir_w = '0;
		glyph.ready = 0;
	end

	function automatic void expect_glyph(glyph_t g);
		pending_glyphs.insert(pending_glyphs.size(), g);
	endfunction

	function automatic void add_row(arrow_t a, bit typed, glyph_t g);
		rows.insert(rows.size(), stim_row_t'{a, typed, g});
	endfunction

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint mulq(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	function automatic longint sat(longint v);
		if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
		if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
		return v;
	endfunction

	function automatic longint row_dot(logic [63:0] ra, logic [63:0] rb,
			longint x, longint y, longint z);
		return mulq(sx(ra[31:0]), x) + mulq(sx(ra[63:32]), y) + mulq(sx(rb[31:0]), z)
			+ sx(rb[63:32]);
	endfunction

	// fixed-point quotient truncated toward zero, then saturated
	function automatic longint div_fix(longint num, longint den);
		bit neg;
		longint unsigned n, d, q0, r, frac, mag;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? longint'(-num) : num;
		d = den < 0 ? longint'(-den) : den;
		q0 = n / d;
		r = n % d;
		frac = 0;
		if (q0 >= (64'd1 << (32 - FB))) return neg ? longint'(WORD_MIN) : longint'(WORD_MAX);
		for (int i = 0; i < FB; i++) begin
			r = r << 1;
			frac = frac << 1;
			if (r >= d) begin
				r = r - d;
				frac = frac | 1;
			end
		end
		mag = (q0 << FB) | frac;
		return neg ? sat(-longint'(mag)) : sat(longint'(mag));
	endfunction

	function automatic void project(longint x, longint y, longint z,
			output longint px, output longint py);
		longint cx, cy, cw;
		cx = row_dot(m_xa, m_xb, x, y, z);
		cy = row_dot(m_ya, m_yb, x, y, z);
		cw = row_dot(m_wa, m_wb, x, y, z);
		if (cw == 0) begin
			px = 0;
			py = 0;
		end else begin
			px = div_fix(cx, cw);
			py = div_fix(cy, cw);
		end
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic glyph_t project_arrow(arrow_t a);
		glyph_t g;
		longint s, tx, ty, tz, p0x, p0y, p1x, p1y, dx, dy, ux, uy, hl, hw, bkx, bky;
		longint unsigned ma, mb, len;
		s = sx(m_scale);
		tx = sat(longint'(a.bx) + mulq(s, a.du));
		ty = sat(longint'(a.by) + mulq(s, a.dv));
		tz = sat(longint'(a.bz) + mulq(s, a.dw));
		project(a.bx, a.by, a.bz, p0x, p0y);
		project(tx, ty, tz, p1x, p1y);
		g.ssx = word_t'(p0x);
		g.ssy = word_t'(p0y);
		g.tsx = word_t'(p1x);
		g.tsy = word_t'(p1y);
		g.ax = 0;
		g.ay = 0;
		g.cx = 0;
		g.cy = 0;
		g.hv = 0;
		dx = p1x - p0x;
		dy = p1y - p0y;
		if (dx != 0 || dy != 0) begin
			ma = dx < 0 ? -dx : dx;
			mb = dy < 0 ? -dy : dy;
			while ((ma | mb) >= (64'd1 << 31)) begin
				ma = ma >> 1;
				mb = mb >> 1;
			end
			while ((ma | mb) < (64'd1 << 30)) begin
				ma = ma << 1;
				mb = mb << 1;
			end
			len = floor_sqrt(ma * ma + mb * mb);
			ux = longint'((ma << FB) / len);
			uy = longint'((mb << FB) / len);
			if (dx < 0) ux = -ux;
			if (dy < 0) uy = -uy;
			hl = sx(m_head[31:0]);
			hw = sx(m_head[63:32]);
			bkx = p1x - mulq(ux, hl);
			bky = p1y - mulq(uy, hl);
			g.ax = word_t'(sat(bkx - mulq(uy, hw)));
			g.ay = word_t'(sat(bky + mulq(ux, hw)));
			g.cx = word_t'(sat(bkx + mulq(uy, hw)));
			g.cy = word_t'(sat(bky - mulq(ux, hw)));
			g.hv = 1;
		end
		return g;
	endfunction

	task automatic report(string field, logic [31:0] exp_v, logic [31:0] got_v);
		$display("mismatch %s: expected %h got %h at %0t", field, exp_v, got_v, $time);
		errors++;
	endtask

	// output side: check, then pick ready for the next cycle
	always @(posedge clk) begin
		glyph_t e;
		if (glyph.valid && glyph.ready) begin
			if (pending_glyphs.size() == 0) begin
				report("unexpected item", '0, '0);
			end else begin
				e = pending_glyphs.pop_front();
				if (glyph.start_sx !== e.ssx) report("start_sx", e.ssx, glyph.start_sx);
				if (glyph.start_sy !== e.ssy) report("start_sy", e.ssy, glyph.start_sy);
				if (glyph.tip_sx !== e.tsx) report("tip_sx", e.tsx, glyph.tip_sx);
				if (glyph.tip_sy !== e.tsy) report("tip_sy", e.tsy, glyph.tip_sy);
				if (glyph.corner_a_x !== e.ax) report("corner_a_x", e.ax, glyph.corner_a_x);
				if (glyph.corner_a_y !== e.ay) report("corner_a_y", e.ay, glyph.corner_a_y);
				if (glyph.corner_b_x !== e.cx) report("corner_b_x", e.cx, glyph.corner_b_x);
				if (glyph.corner_b_y !== e.cy) report("corner_b_y", e.cy, glyph.corner_b_y);
				if (glyph.head_valid !== e.hv)
					report("head_valid", 32'(e.hv), 32'(glyph.head_valid));
			end
		end
		if (hold_left > 0) begin
			glyph.ready <= 0;
			hold_left--;
		end else begin
			glyph.ready <= calm || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		if ((arrow.valid && arrow.ready) || (glyph.valid && glyph.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_arrow(arrow_t a);
		while (!calm && $urandom_range(99) < 18) begin
			arrow.valid <= 0;
			@(posedge clk);
		end
		arrow.valid <= 1;
		arrow.base_x <= a.bx;
		arrow.base_y <= a.by;
		arrow.base_z <= a.bz;
		arrow.dir_u <= a.du;
		arrow.dir_v <= a.dv;
		arrow.dir_w <= a.dw;
		do @(posedge clk); while (!arrow.ready);
	endtask

	task automatic send_predicted(arrow_t a);
		send_arrow(a);
		expect_glyph(project_arrow(a));
	endtask

	task automatic drain();
		arrow.valid <= 0;
		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one write per cycle; the caller lowers the enable after the batch
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (cfg_index_t'(idx))
			CFG_PROJ_X_A: m_xa = val;
			CFG_PROJ_X_B: m_xb = val;
			CFG_PROJ_Y_A: m_ya = val;
			CFG_PROJ_Y_B: m_yb = val;
			CFG_PROJ_W_A: m_wa = val;
			CFG_PROJ_W_B: m_wb = val;
			CFG_ARROW_SCALE: m_scale = val[31:0];
			CFG_HEAD_SIZE: m_head = val;
			default: ;
		endcase
	endtask

	function automatic word_t small_word(int unsigned span);
		return word_t'($urandom_range(2 * span) - span);
	endfunction

	function automatic word_t edge_word();
		case ($urandom_range(5))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return 0;
			3: return -1;
			4: return ONE;
			default: return -ONE;
		endcase
	endfunction

	function automatic word_t pick_word(int mode, int unsigned span);
		if (mode == 0) return word_t'($urandom);
		if (mode == 1) return edge_word();
		return small_word(span);
	endfunction

	task automatic random_config(int mode);
		write_reg(CFG_PROJ_X_A, {pick_word(mode, 1 << 18), pick_word(mode, 1 << 18)});
		write_reg(CFG_PROJ_X_B, {pick_word(mode, 1 << 20), pick_word(mode, 1 << 18)});
		write_reg(CFG_PROJ_Y_A, {pick_word(mode, 1 << 18), pick_word(mode, 1 << 18)});
		write_reg(CFG_PROJ_Y_B, {pick_word(mode, 1 << 20), pick_word(mode, 1 << 18)});
		write_reg(CFG_PROJ_W_A, {pick_word(mode, 1 << 13), pick_word(mode, 1 << 13)});
		if (mode == 2)
			write_reg(CFG_PROJ_W_B, {word_t'($urandom_range(1 << 18, 1 << 15)),
				pick_word(mode, 1 << 13)});
		else
			write_reg(CFG_PROJ_W_B, {pick_word(mode, 1 << 18), pick_word(mode, 1 << 13)});
		write_reg(CFG_ARROW_SCALE, {32'($urandom), pick_word(mode, 1 << 18)});
		write_reg(CFG_HEAD_SIZE, {pick_word(mode, 1 << 17), pick_word(mode, 1 << 17)});
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic arrow_t random_arrow();
		arrow_t a;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			a = '{word_t'($urandom), word_t'($urandom), word_t'($urandom),
				word_t'($urandom), word_t'($urandom), word_t'($urandom)};
		end else if (pick < 15) begin
			a = '{edge_word(), edge_word(), edge_word(), edge_word(), edge_word(), edge_word()};
		end else begin
			a = '{small_word(1 << 21), small_word(1 << 21), small_word(1 << 20),
				small_word(1 << 19), small_word(1 << 19), small_word(1 << 18)};
			// a null shaft now and then
			if (pick < 20) begin
				a.du = 0;
				a.dv = 0;
				a.dw = 0;
			end
		end
		return a;
	endfunction

	task automatic random_items(int count);
		for (int i = 0; i < count; i++) send_predicted(random_arrow());
	endtask

	initial begin
		glyph_t g0;
		m_xa = 64'd65536;
		m_xb = 0;
		m_ya = 64'd65536 << 32;
		m_yb = 0;
		m_wa = 0;
		m_wb = 64'd65536 << 32;
		m_scale = 32'd65536;
		m_head = 0;

		g0 = '{0, 0, 0, 0, 0, 0, 0, 0, 1'b0};
		add_row('{0, 0, 0, 0, 0, 0}, 1, g0);
		add_row('{ONE, 2 * ONE, 0, 0, 0, 0}, 1,
			'{ONE, 2 * ONE, ONE, 2 * ONE, 0, 0, 0, 0, 1'b0});
		add_row('{0, 0, 0, ONE, 0, 0}, 1,
			'{0, 0, ONE, 0, ONE, 0, ONE, 0, 1'b1});
		add_row('{WORD_MAX, 0, 0, 0, 0, 0}, 1,
			'{WORD_MAX, 0, WORD_MAX, 0, 0, 0, 0, 0, 1'b0});
		add_row('{WORD_MIN, WORD_MIN, 0, 0, 0, 0}, 1,
			'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0, 1'b0});
		add_row('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}, 0, g0);
		add_row('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}, 0, g0);
		add_row('{-1, -1, -1, -1, -1, -1}, 0, g0);
		add_row('{ONE, -ONE, 3 * ONE, -2 * ONE, 5 * ONE, ONE}, 0, g0);
		add_row('{0, 0, 0, 0, -ONE, 0}, 0, g0);
		add_row('{WORD_MAX, WORD_MIN, 0, WORD_MIN, WORD_MAX, 0}, 0, g0);

		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_arrow(rows[i].a);
			expect_glyph(rows[i].typed ? rows[i].g : project_arrow(rows[i].a));
		end
		drain();

		// arrowhead with negative length and width, scale of minus two
		write_reg(CFG_HEAD_SIZE, {-ONE / 2, -ONE});
		write_reg(CFG_ARROW_SCALE, 64'hdead_beef_fffe_0000);
		write_reg(IDX_UNUSED, '1);
		cfg_we <= 0;
		@(posedge clk);
		send_predicted('{0, 0, 0, ONE, ONE, 0});
		send_predicted('{ONE, 0, 0, 0, -ONE, 0});
		send_predicted('{WORD_MAX, WORD_MAX, 0, ONE, 0, 0});
		drain();

		// zero w row: every point lands on the origin
		write_reg(CFG_PROJ_W_B, 0);
		cfg_we <= 0;
		@(posedge clk);
		send_predicted('{ONE, ONE, ONE, ONE, ONE, ONE});
		send_predicted('{WORD_MIN, WORD_MAX, 0, WORD_MAX, 0, WORD_MIN});
		drain();

		// all registers at their extremes
		random_config(1);
		for (int i = 0; i < 6; i++) begin
			write_reg(i[CFG_INDEX_W-1:0], (i % 2) ? 64'h8000_0000_8000_0000 : '1);
		end
		write_reg(CFG_ARROW_SCALE, 64'h7fff_ffff);
		write_reg(CFG_HEAD_SIZE, 64'h7fff_ffff_8000_0000);
		cfg_we <= 0;
		@(posedge clk);
		for (int i = 0; i < 8; i++) send_predicted(random_arrow());
		drain();

		for (int phase = 0; phase < 16; phase++) begin
			random_config(phase % 5 == 3 ? 0 : (phase % 5 == 4 ? 1 : 2));
			if (phase == 2) calm = 1;
			if (phase == 5) begin
				// output held off long enough for the pipeline to back up
				calm = 1;
				hold_left = 400;
			end
			random_items(50);
			calm = 0;
			if (phase == 8) begin
				arrow.valid <= 0;
				while (pending_glyphs.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			random_items(50);
			drain();
		end

		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
